@@ sv/f32a_pkg.sv @@
// f32a_pkg: shared types and functions for the binary32 adder.
// No dependencies.
package f32a_pkg;

    localparam logic [22:0] FracMask = 23'h7FFFFF;

    typedef struct packed {
        logic        sign;
        logic        is_zero;
        logic [9:0]  exp;
        logic [26:0] sum;
    } t_raw;

    // leading zero count over 27 bits, bit 26 is the target position
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

endpackage

@@ sv/f32a_align.sv @@
// f32a_align: orders operands, aligns and adds or subtracts mantissas.
// Depends on f32a_pkg.
module f32a_align (
    input  logic [31:0]     i_a,
    input  logic [31:0]     i_b,
    output f32a_pkg::t_raw  o_raw
);
    import f32a_pkg::*;

    logic        sa, sb, sx, sy;
    logic [7:0]  ea, eb, ex, ey, d;
    logic [23:0] ma, mb, mx, my;
    logic [26:0] big, sml, sh, lost_mask;
    logic [27:0] s;
    logic        swap;

    always_comb begin
        sa = i_a[31];
        sb = i_b[31];
        ea = i_a[30:23];
        eb = i_b[30:23];
        ma = (ea == 8'd0) ? 24'd0 : {1'b1, i_a[22:0]};
        mb = (eb == 8'd0) ? 24'd0 : {1'b1, i_b[22:0]};
        swap = (eb > ea) || (eb == ea && mb > ma);
        sx = swap ? sb : sa;
        sy = swap ? sa : sb;
        ex = swap ? eb : ea;
        ey = swap ? ea : eb;
        mx = swap ? mb : ma;
        my = swap ? ma : mb;
        d = ex - ey;
        big = {mx, 3'b000};
        sh = {my, 3'b000};
        lost_mask = (27'd1 << d[4:0]) - 27'd1;
        if (d >= 8'd27) begin
            sml = {26'd0, |sh};
        end else begin
            sml = (sh >> d[4:0]) | {26'd0, |(sh & lost_mask)};
        end
        s = (sx == sy) ? ({1'b0, big} + {1'b0, sml}) : ({1'b0, big} - {1'b0, sml});
        o_raw.is_zero = (s == 28'd0);
        o_raw.sign = (s == 28'd0 && sx != sy) ? 1'b0 : sx;
        if (s[27]) begin
            o_raw.sum = s[27:1] | {26'd0, s[0]};
            o_raw.exp = {2'b00, ex} + 10'd1;
        end else begin
            o_raw.sum = s[26:0];
            o_raw.exp = {2'b00, ex};
        end
    end
endmodule

@@ sv/f32a_round.sv @@
// f32a_round: normalises, rounds to nearest even and packs the result.
// Depends on f32a_pkg.
module f32a_round (
    input  f32a_pkg::t_raw  i_raw,
    output logic [31:0]     o_sum
);
    import f32a_pkg::*;

    logic [4:0]  lz;
    logic [26:0] nsum;
    logic [9:0]  e;
    logic [24:0] m;
    logic        g;

    always_comb begin
        lz = lzc27(i_raw.sum);
        nsum = i_raw.sum << lz;
        e = i_raw.exp - {5'd0, lz};
        g = nsum[2];
        m = {1'b0, nsum[26:3]};
        if (g && (nsum[1:0] != 2'b00 || m[0]))
            m = m + 25'd1;
        if (m[24]) begin
            m = m >> 1;
            e = e + 10'd1;
        end
        if (i_raw.is_zero)
            o_sum = {i_raw.sign, 31'd0};
        else if (!e[9] && e >= 10'd255)
            o_sum = {i_raw.sign, 8'hFF, 23'd0};
        else if (e[9] || e == 10'd0)
            o_sum = {i_raw.sign, 31'd0};
        else
            o_sum = {i_raw.sign, e[7:0], m[22:0] & FracMask};
    end
endmodule

@@ sv/float32_adder.sv @@
// float32_adder: binary32 adder, round to nearest even.
// Result valid once the item moves from the input register into the result register; one item per cycle unless stalled.
// Input register feeds align/add and round logic into a result register.
// Synchronous active-low reset clears the valid flags only.
// Depends on f32a_pkg, f32a_align, f32a_round.
module float32_adder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_sum_bits
);
    import f32a_pkg::*;

    logic        r_in_v, r_out_v;
    logic [31:0] r_a, r_b, r_sum;
    t_raw        raw;
    logic [31:0] sum;
    logic        adv_out, adv_in;

    f32a_align u_align (.i_a(r_a), .i_b(r_b), .o_raw(raw));
    f32a_round u_round (.i_raw(raw), .o_sum(sum));

    assign adv_out = !r_out_v || i_ready;
    assign adv_in  = !r_in_v || adv_out;
    assign o_ready = adv_in;
    assign o_valid = r_out_v;
    assign o_sum_bits = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (adv_in) r_in_v <= i_valid;
            if (adv_out) r_out_v <= r_in_v;
        end
        if (adv_in && i_valid) begin
            r_a <= i_operand_a;
            r_b <= i_operand_b;
        end
        if (adv_out && r_in_v) r_sum <= sum;
    end

`ifndef SYNTH
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sum_bits))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_in_v)
        else $error("accepted item lost");
`endif
endmodule

@@ verif/testbench.sv @@
// Testbench for float32_adder: drives operand pairs through the valid/ready port
// and checks every sum against an in-bench binary32 round-to-nearest-even predictor.
// Depends on float32_adder and f32a_pkg.
`timescale 1ns / 100ps

module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_sum_bits;

    logic [31:0] sums_due[$];
    int          mismatches;
    int          items_sent;
    int          sums_seen;
    int          send_idle_pct;
    int          recv_idle_pct;

    float32_adder u_dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] fp_sum(input logic [31:0] a, input logic [31:0] b);
        logic        sa, sb, t, sgn;
        logic [7:0]  ea, eb, te;
        logic [23:0] ma, mb, tm, m;
        logic [27:0] big, sml, s;
        logic [7:0]  d;
        int          e;
        sa = a[31];
        sb = b[31];
        ea = a[30:23];
        eb = b[30:23];
        ma = (ea == 8'd0) ? 24'd0 : {1'b1, a[22:0]};
        mb = (eb == 8'd0) ? 24'd0 : {1'b1, b[22:0]};
        if (eb > ea || (eb == ea && mb > ma)) begin
            t = sa; sa = sb; sb = t;
            te = ea; ea = eb; eb = te;
            tm = ma; ma = mb; mb = tm;
        end
        d = ea - eb;
        big = {1'b0, ma, 3'b000};
        sml = {1'b0, mb, 3'b000};
        if (d >= 8'd27) begin
            sml = (sml != 28'd0) ? 28'd1 : 28'd0;
        end else if (d > 8'd0) begin
            sml = (sml >> d) | {27'd0, ((sml & ((28'd1 << d) - 28'd1)) != 28'd0)};
        end
        s = (sa == sb) ? big + sml : big - sml;
        if (s == 28'd0) begin
            return {(sa == sb) ? sa : 1'b0, 31'd0};
        end
        sgn = sa;
        e = int'(ea);
        if (s[27]) begin
            s = (s >> 1) | {27'd0, s[0]};
            e++;
        end else begin
            while (!s[26]) begin
                s = s << 1;
                e--;
            end
        end
        m = s[26:3];
        if (s[2] && (s[1:0] != 2'd0 || m[0])) begin
            {t, m} = {1'b0, m} + 25'd1;
            if (t) begin
                m = 24'h800000;
                e++;
            end
        end
        if (e >= 255) begin
            return {sgn, 8'hFF, 23'd0};
        end
        if (e <= 0) begin
            return {sgn, 31'd0};
        end
        return {sgn, 8'(e), m[22:0]};
    endfunction

    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        sums_due.push_back(fp_sum(a, b));
        items_sent++;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sums_seen++;
            if (sums_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected sum %h", o_sum_bits);
                end
            end else begin
                logic [31:0] want;
                want = sums_due.pop_front();
                if (want !== o_sum_bits) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("sum mismatch: expected %h, got %h", want, o_sum_bits);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] rand_operand();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(7))
            0: x[30:23] = 8'd0;
            1: x[30:23] = 8'hFF;
            2: x[30:23] = 8'($urandom_range(250, 255));
            3: x[30:23] = 8'($urandom_range(1, 5));
            default: ;
        endcase
        return x;
    endfunction

    task automatic test_directed();
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h3F80_0000, 32'hBF80_0000);
        send_pair(32'hBF80_0000, 32'h3F80_0000);
        send_pair(32'h007F_FFFF, 32'h3F80_0000);
        send_pair(32'h807F_FFFF, 32'h0000_0001);
        send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_pair(32'hFF7F_FFFF, 32'hFF7F_FFFF);
        send_pair(32'h7F80_0000, 32'h3F80_0000);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000);
        send_pair(32'h0080_0000, 32'h8080_0001);
        send_pair(32'h0080_0001, 32'h8080_0000);
        send_pair(32'h3F80_0000, 32'h3380_0000);
        send_pair(32'h3F80_0001, 32'h3380_0000);
        send_pair(32'h3F80_0000, 32'h3380_0001);
        send_pair(32'h3FFF_FFFF, 32'h3400_0000);
        send_pair(32'h4000_0000, 32'hB380_0000);
        send_pair(32'h3F80_0000, 32'h0080_0000);
        send_pair(32'h4B7F_FFFF, 32'h3F00_0000);
        send_pair(32'h3FC0_0000, 32'h3FC0_0000);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    task automatic test_random(input int count);
        logic [31:0] a, b;
        for (int i = 0; i < count; i++) begin
            a = rand_operand();
            b = rand_operand();
            if ($urandom_range(3) == 0) begin
                b[30:23] = a[30:23] + 8'($urandom_range(2)) - 8'd1;
            end
            if ($urandom_range(7) == 0) begin
                b = {~a[31], a[30:0] ^ 31'($urandom_range(1))};
            end
            send_pair(a, b);
        end
    endtask

    task automatic drain();
        int n;
        n = 0;
        i_valid <= 1'b0;
        while (sums_due.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_operand_a = '0;
        i_operand_b = '0;
        mismatches = 0;
        items_sent = 0;
        sums_seen = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        send_idle_pct = 32;
        recv_idle_pct = 53;
        test_random(540);
        send_idle_pct = 53;
        recv_idle_pct = 32;
        test_random(540);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(550);
        drain();
        if (sums_due.size() != 0) begin
            mismatches++;
        end
        $display("%0d operand pairs sent, %0d sums checked, %0d mismatches",
                 items_sent, sums_seen, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
sv/f32a_pkg.sv
sv/f32a_align.sv
sv/f32a_round.sv
sv/float32_adder.sv
verif/testbench.sv
